>>> rtl/linked_list_queue_manager_assert.svh
// Assertion macros for the linked list queue manager checker.
// Depends on nothing; included by the checker file.
`ifndef LINKED_LIST_QUEUE_MANAGER_ASSERT_SVH
`define LINKED_LIST_QUEUE_MANAGER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LLQM_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("llqm assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LLQM_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("llqm assertion failed");

`endif

>>> rtl/llqm_pkg.sv
// Package for the linked list queue manager: transaction types, codes and states.
// Depends on nothing; used by the top level and the checker.
package llqm_pkg;

    // Field widths fixed by the interface.
    localparam int REQ_W    = 2;
    localparam int NODE_W   = 6;
    localparam int STATUS_W = 2;

    // Request kinds.
    localparam logic [REQ_W-1:0] REQ_PUT    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

    // Input transaction.
    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [NODE_W-1:0] node_index;
    } t_req;

    // Result transaction.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [NODE_W-1:0]   node_out;
        logic                node_valid;
    } t_rsp;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_PUT,
        S_HEAD,
        S_WALK,
        S_FETCH
    } t_state;

endpackage

>>> rtl/llqm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; holds the next-link table of the queue manager.
module llqm_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/linked_list_queue_manager.sv
// Top level of the linked list queue manager: sequencer, head/tail registers
// and the next-link RAM. Depends on llqm_pkg and llqm_ram.
//
// A request is taken when start is high and busy is low, and each request
// gives exactly one result, shown on o_rsp for one cycle with o_strobe high;
// the receiver cannot stall it. Timing is set by the single link RAM with its
// registered read: a pop or delete on an empty list or a request of unknown
// kind returns its result in the cycle after it is taken and busy stays low.
// Put, pop and delete of the head node raise busy for one further state
// (S_PUT or S_HEAD) and return the result registered as it ends. Delete of
// a node further down walks one link per cycle in S_WALK, then fetches the
// link of the found node in S_FETCH; a miss ends at the end of the list or at
// the walk limit. The link RAM needs no clearing pass after reset.
module linked_list_queue_manager #(
    parameter int NODES = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  llqm_pkg::t_req i_req,
    output llqm_pkg::t_rsp o_rsp,
    output logic           o_strobe
);

    localparam int IDX_W      = $clog2(NODES);
    localparam int LINK_W     = $clog2(NODES + 1);
    localparam int NODE_CODES = 2 ** llqm_pkg::NODE_W;
    localparam logic [LINK_W-1:0] LINK_END = LINK_W'(NODES);

    // State registers and their next values.
    llqm_pkg::t_state              r_state, n_state;
    logic [IDX_W-1:0]              r_head, n_head;
    logic [IDX_W-1:0]              r_tail, n_tail;
    logic                          r_empty, n_empty;
    logic [llqm_pkg::REQ_W-1:0]    r_kind, n_kind;
    logic [IDX_W-1:0]              r_node, n_node;
    logic [IDX_W-1:0]              r_prev, n_prev;
    logic [IDX_W-1:0]              r_steps, n_steps;
    logic                          r_strobe, n_strobe;
    llqm_pkg::t_rsp                r_rsp, n_rsp;

    // Link RAM port signals.
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [LINK_W-1:0] wr_data;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [LINK_W-1:0] rd_data;

    // Node index reduced modulo the pool size, through a constant table.
    logic [IDX_W-1:0] mod_tab [NODE_CODES];
    logic [IDX_W-1:0] node_mod;

    for (genvar g = 0; g < NODE_CODES; g++) begin : g_mod_tab
        assign mod_tab[g] = IDX_W'(g % NODES);
    end

    assign node_mod = mod_tab[i_req.node_index];

    // Next-link memory.
    llqm_ram #(
        .WIDTH (LINK_W),
        .DEPTH (NODES)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Sequencer: next state, register updates and RAM accesses.
    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_tail   = r_tail;
        n_empty  = r_empty;
        n_kind   = r_kind;
        n_node   = r_node;
        n_prev   = r_prev;
        n_steps  = r_steps;
        n_strobe = 1'b0;
        n_rsp    = r_rsp;
        wr_en    = 1'b0;
        wr_addr  = '0;
        wr_data  = '0;
        rd_en    = 1'b0;
        rd_addr  = '0;

        case (r_state)
            llqm_pkg::S_IDLE: begin
                if (start) begin
                    n_node = node_mod;
                    n_kind = i_req.req_type;
                    case (i_req.req_type)
                        llqm_pkg::REQ_PUT: begin
                            // Link the current tail to the new node first.
                            if (!r_empty) begin
                                wr_en   = 1'b1;
                                wr_addr = r_tail;
                                wr_data = LINK_W'(node_mod);
                            end
                            n_state = llqm_pkg::S_PUT;
                        end
                        llqm_pkg::REQ_POP: begin
                            if (r_empty) begin
                                n_strobe = 1'b1;
                                n_rsp    = '{status: llqm_pkg::STATUS_EMPTY,
                                             node_out: '0, node_valid: 1'b0};
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = r_head;
                                n_state = llqm_pkg::S_HEAD;
                            end
                        end
                        llqm_pkg::REQ_DELETE: begin
                            if (r_empty) begin
                                n_strobe = 1'b1;
                                n_rsp    = '{status: llqm_pkg::STATUS_EMPTY,
                                             node_out: '0, node_valid: 1'b0};
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = r_head;
                                n_prev  = r_head;
                                n_steps = '0;
                                n_state = (r_head == node_mod) ? llqm_pkg::S_HEAD
                                                               : llqm_pkg::S_WALK;
                            end
                        end
                        default: begin
                            // Unknown kind: no operation, plain success.
                            n_strobe = 1'b1;
                            n_rsp    = '{status: llqm_pkg::STATUS_OK,
                                         node_out: '0, node_valid: 1'b0};
                        end
                    endcase
                end
            end

            llqm_pkg::S_PUT: begin
                // Terminate the new node and make it the tail.
                if (r_empty) begin
                    n_head  = r_node;
                    n_empty = 1'b0;
                end
                n_tail   = r_node;
                wr_en    = 1'b1;
                wr_addr  = r_node;
                wr_data  = LINK_END;
                n_strobe = 1'b1;
                n_rsp    = '{status: llqm_pkg::STATUS_OK, node_out: '0, node_valid: 1'b0};
                n_state  = llqm_pkg::S_IDLE;
            end

            llqm_pkg::S_HEAD: begin
                // Remove the head node; the link of the head is on rd_data.
                if (r_head == r_tail || rd_data >= LINK_END) begin
                    n_empty = 1'b1;
                    n_head  = '0;
                    n_tail  = '0;
                end else begin
                    n_head = rd_data[IDX_W-1:0];
                end
                n_strobe = 1'b1;
                if (r_kind == llqm_pkg::REQ_POP) begin
                    n_rsp = '{status: llqm_pkg::STATUS_OK,
                              node_out: llqm_pkg::NODE_W'(r_head), node_valid: 1'b1};
                end else begin
                    n_rsp = '{status: llqm_pkg::STATUS_OK, node_out: '0, node_valid: 1'b0};
                end
                n_state = llqm_pkg::S_IDLE;
            end

            llqm_pkg::S_WALK: begin
                // rd_data is the link of r_prev.
                if (rd_data >= LINK_END) begin
                    n_strobe = 1'b1;
                    n_rsp    = '{status: llqm_pkg::STATUS_NOT_FOUND,
                                 node_out: '0, node_valid: 1'b0};
                    n_state  = llqm_pkg::S_IDLE;
                end else if (rd_data == LINK_W'(r_node)) begin
                    // Found: fetch the link of the node to splice it out.
                    rd_en   = 1'b1;
                    rd_addr = r_node;
                    n_state = llqm_pkg::S_FETCH;
                end else if (r_steps == IDX_W'(NODES - 1)) begin
                    // Walk limit reached without a match.
                    n_strobe = 1'b1;
                    n_rsp    = '{status: llqm_pkg::STATUS_NOT_FOUND,
                                 node_out: '0, node_valid: 1'b0};
                    n_state  = llqm_pkg::S_IDLE;
                end else begin
                    n_prev  = rd_data[IDX_W-1:0];
                    n_steps = r_steps + 1'b1;
                    rd_en   = 1'b1;
                    rd_addr = rd_data[IDX_W-1:0];
                end
            end

            llqm_pkg::S_FETCH: begin
                // Point the predecessor past the deleted node.
                wr_en   = 1'b1;
                wr_addr = r_prev;
                wr_data = rd_data;
                if (r_node == r_tail) begin
                    n_tail = r_prev;
                end
                n_strobe = 1'b1;
                n_rsp    = '{status: llqm_pkg::STATUS_OK, node_out: '0, node_valid: 1'b0};
                n_state  = llqm_pkg::S_IDLE;
            end

            default: begin
                n_state = llqm_pkg::S_IDLE;
            end
        endcase
    end

    // Control state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= llqm_pkg::S_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_empty  <= 1'b1;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_empty  <= n_empty;
            r_strobe <= n_strobe;
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_node  <= n_node;
        r_prev  <= n_prev;
        r_steps <= n_steps;
        r_rsp   <= n_rsp;
    end

    assign busy     = (r_state != llqm_pkg::S_IDLE);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule

>>> rtl/llqm_checker.sv
// Port-level checker for the linked list queue manager, bound to the top level.
// Depends on llqm_pkg and linked_list_queue_manager_assert.svh.
`include "linked_list_queue_manager_assert.svh"

module llqm_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input llqm_pkg::t_req i_req,
    input llqm_pkg::t_rsp o_rsp,
    input logic           o_strobe
);

    logic put_taken;
    logic popped_rsp;
    logic plain_rsp;

    // Conditions watched by the assertions below.
    assign put_taken  = start && !busy && i_req.req_type == llqm_pkg::REQ_PUT;
    assign popped_rsp = o_strobe && o_rsp.node_valid;
    assign plain_rsp  = o_strobe && !o_rsp.node_valid;

    // A result never carries the unused status code.
    `LLQM_ASSERT_IMPLY(a_status_code, i_clk, i_rst_n, o_strobe, o_rsp.status <= llqm_pkg::STATUS_NOT_FOUND)

    // A popped node is only reported with a success status.
    `LLQM_ASSERT_IMPLY(a_pop_ok, i_clk, i_rst_n, popped_rsp, o_rsp.status == llqm_pkg::STATUS_OK)

    // Without a popped node the node field reads zero.
    `LLQM_ASSERT_IMPLY(a_node_zero, i_clk, i_rst_n, plain_rsp, o_rsp.node_out == '0)

    // Busy only rises right after a transaction was taken.
    `LLQM_ASSERT_IMPLY(a_busy_cause, i_clk, i_rst_n, $rose(busy), $past(start))

    // A taken put is always followed by busy high.
    `LLQM_ASSERT_NEXT(a_put_busy, i_clk, i_rst_n, put_taken, busy)

endmodule

bind linked_list_queue_manager llqm_checker u_llqm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_req    (i_req),
    .o_rsp    (o_rsp),
    .o_strobe (o_strobe)
);

>>> tb/testbench.sv
// Testbench for the linked list queue manager: a clocked driver and result checker
// around a behavioral list model that predicts every response. Depends on llqm_pkg.
module testbench;
    import llqm_pkg::*;

    localparam int NODES = 64;
    localparam logic [6:0] LINK_END = 7'd64;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_ITEMS = 800;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_req i_req = '0;
    t_rsp o_rsp;
    logic o_strobe;

    // Requests waiting to be driven and responses waiting to arrive.
    t_req pending_req[$];
    t_rsp expected_rsp[$];

    // Order of nodes in the list as the stimulus plan sees it.
    int planned_order[$];

    // Predicted list state.
    logic [6:0] link_mem [NODES] = '{default: '0};
    logic [5:0] head_node = '0;
    logic [5:0] tail_node = '0;
    bit list_is_empty = 1'b1;

    int total_items = 0;
    int accepted_cnt = 0;
    int fail_cnt = 0;
    int idle_cycles = 0;
    int burst_left = 1;
    int gap_left = 0;

    linked_list_queue_manager #(.NODES(NODES)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .o_strobe(o_strobe)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Empty the predicted list.
    function automatic void drop_all_nodes();
        list_is_empty = 1'b1;
        head_node = '0;
        tail_node = '0;
    endfunction

    // Apply one request to the predicted list and return the response it gives.
    function automatic t_rsp list_step(t_req rq);
        t_rsp rsp;
        logic [6:0] nx;
        logic [5:0] prev;
        logic [5:0] idx;
        int steps;
        bit walking;
        rsp = '0;
        rsp.status = STATUS_OK;
        idx = rq.node_index;
        case (rq.req_type)
            REQ_PUT: begin
                if (list_is_empty) begin
                    head_node = idx;
                    list_is_empty = 1'b0;
                end else begin
                    link_mem[tail_node] = {1'b0, idx};
                end
                tail_node = idx;
                link_mem[idx] = LINK_END;
            end
            REQ_POP: begin
                if (list_is_empty) begin
                    rsp.status = STATUS_EMPTY;
                end else begin
                    nx = link_mem[head_node];
                    rsp.node_out = head_node;
                    rsp.node_valid = 1'b1;
                    if (head_node == tail_node || nx >= LINK_END) drop_all_nodes();
                    else head_node = nx[5:0];
                end
            end
            REQ_DELETE: begin
                if (list_is_empty) begin
                    rsp.status = STATUS_EMPTY;
                end else if (head_node == idx) begin
                    nx = link_mem[head_node];
                    if (head_node == tail_node || nx >= LINK_END) drop_all_nodes();
                    else head_node = nx[5:0];
                end else begin
                    // Walk from the head, bounded so that a looped list still ends.
                    rsp.status = STATUS_NOT_FOUND;
                    prev = head_node;
                    walking = 1'b1;
                    steps = 0;
                    while (walking && steps < NODES) begin
                        nx = link_mem[prev];
                        if (nx >= LINK_END) begin
                            walking = 1'b0;
                        end else if (nx[5:0] == idx) begin
                            link_mem[prev] = link_mem[idx];
                            if (idx == tail_node) tail_node = prev;
                            rsp.status = STATUS_OK;
                            walking = 1'b0;
                        end else begin
                            prev = nx[5:0];
                        end
                        steps++;
                    end
                end
            end
            default: begin
            end
        endcase
        return rsp;
    endfunction

    // Position of a node in the planned order, or -1 when it is not there.
    function automatic int planned_pos(int idx);
        foreach (planned_order[k]) begin
            if (planned_order[k] == idx) return k;
        end
        return -1;
    endfunction

    // Queue one request and track its effect on the planned order.
    task automatic plan(input logic [REQ_W-1:0] kind, input int idx);
        t_req rq;
        int pos;
        rq.req_type = kind;
        rq.node_index = idx[NODE_W-1:0];
        pending_req.push_back(rq);
        pos = planned_pos(idx);
        case (kind)
            REQ_PUT: begin
                // Putting a listed node again cuts the list off behind it.
                if (pos < 0) planned_order.push_back(idx);
                else while (planned_order.size() > pos + 1) void'(planned_order.pop_back());
            end
            REQ_POP: begin
                if (planned_order.size() > 0) void'(planned_order.pop_front());
            end
            REQ_DELETE: begin
                if (pos >= 0) planned_order.delete(pos);
            end
            default: begin
            end
        endcase
    endtask

    // Pick a node that the planned list does not hold.
    function automatic int absent_node();
        int idx;
        idx = $urandom_range(0, NODES - 1);
        while (planned_pos(idx) >= 0) idx = $urandom_range(0, NODES - 1);
        return idx;
    endfunction

    // Driver: presents requests in bursts with random gaps between them.
    always @(posedge i_clk) begin : drive
        logic next_start;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            next_start = start;
            if (start && !busy) begin
                expected_rsp.push_back(list_step(i_req));
                accepted_cnt++;
                next_start = 1'b0;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            if (!next_start) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_req.size() > 0) begin
                    i_req <= pending_req.pop_front();
                    next_start = 1'b1;
                end
            end
            start <= next_start;
        end
    end

    // Checker: every strobed response must match the oldest prediction.
    always @(posedge i_clk) begin : check
        t_rsp want;
        if (i_rst_n && o_strobe) begin
            if (expected_rsp.size() == 0) begin
                if (fail_cnt < 10)
                    $display("unexpected response: st %0d node %0d valid %0b",
                             o_rsp.status, o_rsp.node_out, o_rsp.node_valid);
                fail_cnt++;
            end else begin
                want = expected_rsp.pop_front();
                if (o_rsp.status !== want.status || o_rsp.node_out !== want.node_out ||
                    o_rsp.node_valid !== want.node_valid) begin
                    if (fail_cnt < 10)
                        $display("mismatch: exp st %0d node %0d valid %0b, got st %0d node %0d valid %0b",
                                 want.status, want.node_out, want.node_valid,
                                 o_rsp.status, o_rsp.node_out, o_rsp.node_valid);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus plan, reset and end of run.
    initial begin : stimulus
        int mode;
        int roll;
        int put_weight;
        int idx;
        // Directed part: empty list, tail, middle and head deletes, misses,
        // unused request kind and repeated puts of a listed node.
        plan(REQ_POP, 0);
        plan(REQ_DELETE, 63);
        plan(REQ_UNUSED, 0);
        plan(REQ_PUT, 0);
        plan(REQ_PUT, 63);
        plan(REQ_PUT, 21);
        plan(REQ_PUT, 42);
        plan(REQ_DELETE, 42);
        plan(REQ_DELETE, 5);
        plan(REQ_DELETE, 63);
        plan(REQ_PUT, 42);
        plan(REQ_DELETE, 0);
        plan(REQ_POP, 0);
        plan(REQ_UNUSED, 63);
        plan(REQ_POP, 63);
        plan(REQ_POP, 0);
        plan(REQ_PUT, 7);
        plan(REQ_DELETE, 7);
        plan(REQ_PUT, 7);
        plan(REQ_PUT, 7);
        plan(REQ_PUT, 12);
        plan(REQ_PUT, 7);
        plan(REQ_POP, 0);
        plan(REQ_DELETE, 0);

        // Random part: phases that grow, drain or hold the list length.
        mode = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) mode = $urandom_range(0, 2);
            put_weight = (mode == 0) ? 65 : (mode == 1) ? 20 : 45;
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
                plan(REQ_UNUSED, $urandom_range(0, NODES - 1));
            end else if (roll < 4) begin
                plan($urandom_range(0, 2), $urandom_range(0, NODES - 1));
            end else if (roll < 5 && planned_order.size() > 0) begin
                idx = planned_order[$urandom_range(0, planned_order.size() - 1)];
                plan(REQ_PUT, idx);
            end else if ($urandom_range(0, 99) < put_weight && planned_order.size() < NODES) begin
                plan(REQ_PUT, absent_node());
            end else if ($urandom_range(0, 99) < 40) begin
                plan(REQ_POP, $urandom_range(0, NODES - 1));
            end else if (planned_order.size() > 0 && $urandom_range(0, 99) < 80) begin
                idx = planned_order[$urandom_range(0, planned_order.size() - 1)];
                plan(REQ_DELETE, idx);
            end else if (planned_order.size() < NODES) begin
                plan(REQ_DELETE, absent_node());
            end else begin
                plan(REQ_POP, 0);
            end
        end
        total_items = pending_req.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_cnt < total_items || expected_rsp.size() > 0) @(posedge i_clk);
        repeat (NODES + 4) @(posedge i_clk);

        if (fail_cnt == 0 && expected_rsp.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
